// File: hdl/rc4_pkg.sv
// rc4_pkg: shared types and constants for the RC4 stream cipher core.
// No dependencies; imported by rc4_apb_regs, rc4_engine and the top level.
`default_nettype none

package rc4_pkg;

    // Permutation table geometry
    localparam int PERM_DEPTH = 'h100;
    localparam int PERM_AW    = 8;

    // Key store default depth, key_length register width and reset value
    localparam int KEY_MAX_DEF = 256;
    localparam int KEY_LEN_W   = 9;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 9'd16;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_KEY_LEN = 1'b0;

    // Request kinds (carried in tuser)
    localparam logic [1:0] ACT_LOAD_KEY = 2'd0;
    localparam logic [1:0] ACT_REKEY    = 2'd1;
    localparam logic [1:0] ACT_DATA     = 2'd2;

    // Result handed from the engine to the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       not_keyed;
    } res_t;

endpackage

`default_nettype wire

// File: hdl/rc4_stream_cipher_core.sv
// rc4_stream_cipher_core: top level of the RC4 engine: stream ports, APB
// register port, output register. Depends on rc4_pkg, rc4_apb_regs, rc4_engine.
//
//  Port group  Dir  Handshake            Contents
//  s_axis      in   tvalid/tready        tuser: action; tdata: key_index, byte_value
//  m_axis      out  tvalid/tready        tuser: not_keyed; tdata: out_byte
//  apb         in   psel/penable/pready  key_length at byte address 0
//
// A key byte is written to the key memory on acceptance. A data byte runs
// accept, read S[j], swap write plus read S[a+b], final write, set by the
// single read and single write port of the permutation memory. A data byte
// before the first rekey is accepted, then answered as not keyed. A rekey runs
// an identity fill of S, then per schedule step K_RJ, K_WJ and K_WI.
// Reset clears indices, keyed flag and key_length (16); the memories are not
// cleared. A result waits in the output register while the next request is
// accepted; the engine holds only at its final cycle if that register is full.
`default_nettype none

module rc4_stream_cipher_core #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // request stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [15:0]                 s_axis_tdata,  // [7:0] key_index, [15:8] byte_value
    input  wire logic [1:0]                  s_axis_tuser,  // [1:0] action
    // result stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [7:0]                  m_axis_tdata,  // [7:0] out_byte
    output logic      [0:0]                  m_axis_tuser,  // [0] not_keyed
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rc4_pkg::APB_AW-1:0]  paddr,
    input  wire logic [rc4_pkg::APB_DW-1:0]  pwdata,
    output logic      [rc4_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import rc4_pkg::*;

    logic [KEY_LEN_W-1:0] key_length;
    res_t                 res;
    logic                 slot_free;

    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_nk_reg;

    rc4_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .key_length (key_length)
    );

    rc4_engine #(
        .KEY_MAX (KEY_MAX)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .action     (s_axis_tuser),
        .key_index  (s_axis_tdata[7:0]),
        .byte_value (s_axis_tdata[15:8]),
        .key_length (key_length),
        .slot_free  (slot_free),
        .res        (res)
    );

    // output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_byte_reg <= res.out_byte;
            out_nk_reg   <= res.not_keyed;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_byte_reg;
    assign m_axis_tuser[0] = out_nk_reg;

endmodule

`default_nettype wire

// File: hdl/rc4_apb_regs.sv
// rc4_apb_regs: APB register file holding key_length.
// Depends on rc4_pkg.
`default_nettype none

module rc4_apb_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rc4_pkg::APB_AW-1:0]      paddr,
    input  wire logic [rc4_pkg::APB_DW-1:0]      pwdata,
    output logic      [rc4_pkg::APB_DW-1:0]      prdata,
    output logic                                 pready,
    output logic      [rc4_pkg::KEY_LEN_W-1:0]   key_length
);
    import rc4_pkg::*;

    logic [KEY_LEN_W-1:0] key_length_reg;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KEY_LEN_RST;
        end
        else if (wr_en && (paddr[2] == REG_KEY_LEN))
        begin
            key_length_reg <= pwdata[KEY_LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_KEY_LEN)
        begin
            prdata = {{(APB_DW-KEY_LEN_W){1'b0}}, key_length_reg};
        end
    end

    assign key_length = key_length_reg;

endmodule

`default_nettype wire

// File: hdl/rc4_engine.sv
// rc4_engine: permutation and key memories plus the sequencer that runs the
// key schedule and the keystream generator. Depends on rc4_pkg.
`default_nettype none

module rc4_engine #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire logic [1:0]                     action,
    input  wire logic [7:0]                     key_index,
    input  wire logic [7:0]                     byte_value,
    input  wire logic [rc4_pkg::KEY_LEN_W-1:0]  key_length,
    input  wire logic                           slot_free,
    output rc4_pkg::res_t                       res
);
    import rc4_pkg::*;

    localparam int KW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KLW = $clog2(KEY_MAX + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_NK   = 4'd1;
    localparam logic [3:0] ST_INIT = 4'd2;
    localparam logic [3:0] ST_K_RJ = 4'd3;
    localparam logic [3:0] ST_K_WJ = 4'd4;
    localparam logic [3:0] ST_K_WI = 4'd5;
    localparam logic [3:0] ST_D_RJ = 4'd6;
    localparam logic [3:0] ST_D_WJ = 4'd7;
    localparam logic [3:0] ST_D_WI = 4'd8;

    localparam logic [PERM_AW-1:0] LAST_IDX = PERM_AW'(PERM_DEPTH - 1);

    // Memories
    logic [7:0] perm_mem [PERM_DEPTH];
    logic [7:0] key_mem  [KEY_MAX];

    logic               perm_we;
    logic [PERM_AW-1:0] perm_waddr;
    logic [7:0]         perm_wdata;
    logic               perm_re;
    logic [PERM_AW-1:0] perm_raddr;
    logic [7:0]         perm_rdata_reg;

    logic               key_we;
    logic [KW-1:0]      key_waddr;
    logic               key_re;
    logic [KW-1:0]      key_raddr;
    logic [7:0]         key_rdata_reg;

    // Control and datapath registers
    logic [3:0]         state_reg, state_next;
    logic [PERM_AW-1:0] i_reg, i_next;
    logic [PERM_AW-1:0] j_reg, j_next;
    logic               keyed_reg, keyed_next;
    logic [PERM_AW-1:0] k_reg, k_next;
    logic [KW-1:0]      kp_reg, kp_next;
    logic [7:0]         a_reg, a_next;
    logic [7:0]         b_reg, b_next;
    logic [7:0]         data_reg, data_next;
    logic               fwd_i_reg, fwd_i_next;
    logic               fwd_j_reg, fwd_j_next;

    logic [KLW-1:0]     key_n;
    logic [KW-1:0]      kp_step;
    logic [PERM_AW-1:0] jn;
    logic [PERM_AW-1:0] t_idx;
    logic [7:0]         ks_byte;
    logic               accept;

    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm_mem[perm_waddr] <= perm_wdata;
        end
        if (perm_re)
        begin
            perm_rdata_reg <= perm_mem[perm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= byte_value;
        end
        if (key_re)
        begin
            key_rdata_reg <= key_mem[key_raddr];
        end
    end

    // Effective key length: zero acts as one, saturate at KEY_MAX
    always_comb
    begin
        if (key_length == '0)
        begin
            key_n = KLW'(1);
        end
        else if (key_length > KEY_LEN_W'(KEY_MAX))
        begin
            key_n = KLW'(KEY_MAX);
        end
        else
        begin
            key_n = KLW'(key_length);
        end
    end

    // key position wraps at key_n
    assign kp_step = ((KLW'(kp_reg) + KLW'(1)) == key_n) ? '0 : kp_reg + KW'(1);

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    assign ks_byte = fwd_j_reg ? a_reg : (fwd_i_reg ? b_reg : perm_rdata_reg);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        keyed_next = keyed_reg;
        k_next     = k_reg;
        kp_next    = kp_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        data_next  = data_reg;
        fwd_i_next = fwd_i_reg;
        fwd_j_next = fwd_j_reg;

        perm_we    = 1'b0;
        perm_waddr = '0;
        perm_wdata = '0;
        perm_re    = 1'b0;
        perm_raddr = '0;
        key_we     = 1'b0;
        key_waddr  = key_index[KW-1:0];
        key_re     = 1'b0;
        key_raddr  = '0;

        jn    = '0;
        t_idx = '0;

        res.valid     = 1'b0;
        res.out_byte  = '0;
        res.not_keyed = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (action == ACT_LOAD_KEY)
                    begin
                        key_we = (9'(key_index) < 9'(KEY_MAX));
                    end
                    else if (action == ACT_REKEY)
                    begin
                        k_next     = '0;
                        j_next     = '0;
                        state_next = ST_INIT;
                    end
                    else if (action == ACT_DATA)
                    begin
                        data_next = byte_value;
                        if (keyed_reg)
                        begin
                            i_next     = i_reg + PERM_AW'(1);
                            perm_re    = 1'b1;
                            perm_raddr = i_reg + PERM_AW'(1);
                            state_next = ST_D_RJ;
                        end
                        else
                        begin
                            state_next = ST_NK;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_NK:
            begin
                res.valid     = slot_free;
                res.not_keyed = 1'b1;
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            // identity fill; last cycle also fetches S[0] and key[0]
            ST_INIT:
            begin
                perm_we    = 1'b1;
                perm_waddr = k_reg;
                perm_wdata = k_reg;
                k_next     = k_reg + PERM_AW'(1);
                if (k_reg == LAST_IDX)
                begin
                    perm_re    = 1'b1;
                    perm_raddr = '0;
                    key_re     = 1'b1;
                    key_raddr  = '0;
                    kp_next    = '0;
                    state_next = ST_K_RJ;
                end
            end

            ST_K_RJ:
            begin
                jn         = j_reg + perm_rdata_reg + key_rdata_reg;
                a_next     = perm_rdata_reg;
                j_next     = jn;
                perm_re    = 1'b1;
                perm_raddr = jn;
                state_next = ST_K_WJ;
            end

            ST_K_WJ:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = a_reg;
                b_next     = perm_rdata_reg;
                state_next = ST_K_WI;
            end

            // write S[k]; overlap the next step's reads (address k+1 != k)
            ST_K_WI:
            begin
                perm_we    = 1'b1;
                perm_waddr = k_reg;
                perm_wdata = b_reg;
                if (k_reg == LAST_IDX)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + PERM_AW'(1);
                    kp_next    = kp_step;
                    perm_re    = 1'b1;
                    perm_raddr = k_reg + PERM_AW'(1);
                    key_re     = 1'b1;
                    key_raddr  = kp_step;
                    state_next = ST_K_RJ;
                end
            end

            ST_D_RJ:
            begin
                jn         = j_reg + perm_rdata_reg;
                a_next     = perm_rdata_reg;
                j_next     = jn;
                perm_re    = 1'b1;
                perm_raddr = jn;
                state_next = ST_D_WJ;
            end

            // S[j] <= a while reading S[a+b]; swap hits are forwarded
            ST_D_WJ:
            begin
                t_idx      = a_reg + perm_rdata_reg;
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = a_reg;
                b_next     = perm_rdata_reg;
                perm_re    = 1'b1;
                perm_raddr = t_idx;
                fwd_i_next = (t_idx == i_reg);
                fwd_j_next = (t_idx == j_reg);
                state_next = ST_D_WI;
            end

            ST_D_WI:
            begin
                perm_we      = 1'b1;
                perm_waddr   = i_reg;
                perm_wdata   = b_reg;
                res.valid    = slot_free;
                res.out_byte = data_reg ^ ks_byte;
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            keyed_reg <= 1'b0;
            k_reg     <= '0;
            kp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            keyed_reg <= keyed_next;
            k_reg     <= k_next;
            kp_reg    <= kp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        data_reg  <= data_next;
        fwd_i_reg <= fwd_i_next;
        fwd_j_reg <= fwd_j_next;
    end

    // Assertions
    a_res_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> slot_free)
        else $error("result issued while output slot busy");

    a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        keyed_reg |=> keyed_reg)
        else $error("keyed flag dropped");

    a_nk_only_unkeyed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NK) |-> !keyed_reg)
        else $error("not-keyed result while keyed");

    a_keystream_keyed: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.not_keyed) |-> keyed_reg)
        else $error("keystream result before key schedule");

    a_ksa_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_K_WI && k_reg == LAST_IDX) |=> (state_reg == ST_IDLE && keyed_reg))
        else $error("key schedule did not finish cleanly");

endmodule

`default_nettype wire
